FILE: hdl/skew_lines_closest_midpoint_top_assert.svh
// Assertion macros for the closest-midpoint block checker.
`ifndef SKEW_LINES_CLOSEST_MIDPOINT_TOP_ASSERT_SVH
`define SKEW_LINES_CLOSEST_MIDPOINT_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define SLCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define SLCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/slcm_pkg.sv
// Shared widths, constants and item types for the closest-midpoint block.
package slcm_pkg;

    localparam int W_IN       = 32;
    localparam int W_D        = W_IN + 1;        // p1 - p2, p1 + p2
    localparam int W_PA       = 2 * W_IN;        // u * u product
    localparam int W_N        = W_PA + 1;        // n = u1 x u2
    localparam int W_PC       = W_D + W_IN;      // d * u product
    localparam int W_C        = W_PC + 1;        // d x u
    localparam int W_PNN      = 2 * W_N;         // n_k * n_k
    localparam int W_PT       = W_C + W_N;       // c_k * n_k
    localparam int W_DS       = W_PNN + 1;       // D = n.n
    localparam int W_T        = W_PT + 1;        // (d x u).n and its negation
    localparam int W_PS       = W_D + W_DS;      // S * D
    localparam int W_PU       = W_T + W_IN;      // N * u
    localparam int W_A        = W_PS + 2;        // offset numerator
    localparam int W_B        = W_DS + 1;        // 2 * D
    localparam int Q_BITS     = W_IN;
    localparam int MUL_CHUNK  = 32;
    localparam int MUL_LEAVES = 16;
    localparam int MUL_LAT    = 5;               // product stage plus four adder levels

    localparam logic signed [W_IN-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [W_IN-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [W_IN-1:0] first_point_x;
        logic signed [W_IN-1:0] first_point_y;
        logic signed [W_IN-1:0] first_point_z;
        logic signed [W_IN-1:0] first_dir_x;
        logic signed [W_IN-1:0] first_dir_y;
        logic signed [W_IN-1:0] first_dir_z;
        logic signed [W_IN-1:0] second_point_x;
        logic signed [W_IN-1:0] second_point_y;
        logic signed [W_IN-1:0] second_point_z;
        logic signed [W_IN-1:0] second_dir_x;
        logic signed [W_IN-1:0] second_dir_y;
        logic signed [W_IN-1:0] second_dir_z;
    } t_in_item;

    typedef struct packed {
        logic signed [W_IN-1:0] closest_x;
        logic signed [W_IN-1:0] closest_y;
        logic signed [W_IN-1:0] closest_z;
        logic                   lines_parallel;
    } t_out_item;

endpackage

FILE: hdl/slcm_mul.sv
// Pipelined signed multiplier: 33x33 chunk products summed by a registered tree.
module slcm_mul #(
    parameter int WX = 32,
    parameter int WY = 32
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WX-1:0]    i_x,
    input  logic signed [WY-1:0]    i_y,
    output logic signed [WX+WY-1:0] o_p
);
    import slcm_pkg::*;

    localparam int WP = WX + WY;
    localparam int NX = (WX + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NY = (WY + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int XE = NX * MUL_CHUNK;
    localparam int YE = NY * MUL_CHUNK;

    logic signed [XE-1:0] x_ext;
    logic signed [YE-1:0] y_ext;
    logic signed [WP-1:0] n_pp [MUL_LEAVES];
    logic signed [WP-1:0] r_pp [MUL_LEAVES];
    logic signed [WP-1:0] r_l1 [MUL_LEAVES/2];
    logic signed [WP-1:0] r_l2 [MUL_LEAVES/4];
    logic signed [WP-1:0] r_l3 [MUL_LEAVES/8];
    logic signed [WP-1:0] r_l4;

    assign x_ext = XE'(i_x);
    assign y_ext = YE'(i_y);

    genvar gi, gj, gk;
    for (gi = 0; gi < NX; gi++) begin : g_px
        for (gj = 0; gj < NY; gj++) begin : g_py
            logic signed [MUL_CHUNK:0]     xc;
            logic signed [MUL_CHUNK:0]     yc;
            logic signed [2*MUL_CHUNK+1:0] prod;
            // only the top chunk carries the sign
            if (gi == NX - 1) begin : g_xs
                assign xc = {x_ext[XE-1], x_ext[gi*MUL_CHUNK +: MUL_CHUNK]};
            end else begin : g_xu
                assign xc = {1'b0, x_ext[gi*MUL_CHUNK +: MUL_CHUNK]};
            end
            if (gj == NY - 1) begin : g_ys
                assign yc = {y_ext[YE-1], y_ext[gj*MUL_CHUNK +: MUL_CHUNK]};
            end else begin : g_yu
                assign yc = {1'b0, y_ext[gj*MUL_CHUNK +: MUL_CHUNK]};
            end
            assign prod = xc * yc;
            assign n_pp[gi*NY+gj] = WP'(prod) <<< (MUL_CHUNK * (gi + gj));
        end
    end
    for (gk = NX * NY; gk < MUL_LEAVES; gk++) begin : g_pad
        assign n_pp[gk] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < MUL_LEAVES; k++) begin
                r_pp[k] <= n_pp[k];
            end
            for (int k = 0; k < MUL_LEAVES / 2; k++) begin
                r_l1[k] <= r_pp[2*k] + r_pp[2*k+1];
            end
            for (int k = 0; k < MUL_LEAVES / 4; k++) begin
                r_l2[k] <= r_l1[2*k] + r_l1[2*k+1];
            end
            for (int k = 0; k < MUL_LEAVES / 8; k++) begin
                r_l3[k] <= r_l2[2*k] + r_l2[2*k+1];
            end
            r_l4 <= r_l3[0] + r_l3[1];
        end
    end

    assign o_p = r_l4;

endmodule

FILE: hdl/slcm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with 32-bit saturation.
module slcm_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [slcm_pkg::W_A-1:0] i_num,
    input  logic [slcm_pkg::W_B-1:0]       i_den,
    output logic signed [slcm_pkg::Q_BITS-1:0] o_quo
);
    import slcm_pkg::*;

    // numerator arrives offset by 2^31 * den, so the quotient is unsigned here
    logic [W_A-1:0]    r_rem [Q_BITS];
    logic [W_B-1:0]    r_den [Q_BITS];
    logic [Q_BITS-1:0] r_q   [1:Q_BITS];
    logic [Q_BITS:0]   r_neg;
    logic [Q_BITS:0]   r_big;
    logic [W_A-1:0]    n_shd [Q_BITS];
    logic [W_A:0]      n_dif [Q_BITS];
    logic              n_neg;
    logic              n_big;

    assign n_neg = i_num[W_A-1];
    assign n_big = !n_neg && ($unsigned(i_num) >= (W_A'(i_den) << Q_BITS));

    always_comb begin
        for (int k = 0; k < Q_BITS; k++) begin
            n_shd[k] = W_A'(r_den[k]) << (Q_BITS - 1 - k);
            n_dif[k] = {1'b0, r_rem[k]} - {1'b0, n_shd[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= $unsigned(i_num);
            r_den[0] <= i_den;
            r_neg    <= {r_neg[Q_BITS-1:0], n_neg};
            r_big    <= {r_big[Q_BITS-1:0], n_big};
            r_q[1]   <= Q_BITS'(!n_dif[0][W_A]);
            for (int k = 1; k < Q_BITS; k++) begin
                r_rem[k]   <= n_dif[k-1][W_A] ? r_rem[k-1] : n_dif[k-1][W_A-1:0];
                r_den[k]   <= r_den[k-1];
                r_q[k+1]   <= {r_q[k][Q_BITS-2:0], !n_dif[k][W_A]};
            end
        end
    end

    always_comb begin
        if (r_neg[Q_BITS]) begin
            o_quo = SAT_MIN;
        end else if (r_big[Q_BITS]) begin
            o_quo = SAT_MAX;
        end else begin
            o_quo = {~r_q[Q_BITS][Q_BITS-1], r_q[Q_BITS][Q_BITS-2:0]};
        end
    end

endmodule

FILE: hdl/skew_lines_closest_midpoint_top.sv
// Closest-approach midpoint of two 3D lines: top level pipeline.
//
// Takes one item (two lines, each a point and a direction, signed Q16.16) per clock and
// returns the midpoint of their common perpendicular, saturated to 32 bits, with
// lines_parallel set when the direction cross product is zero (then the midpoint of the
// two points comes back). Every stage is registered and fully pipelined: three
// multiplier tree sections of five stages each and a 33-stage divider that resolves one
// quotient bit per stage. A new item is taken every cycle unless the pipeline holds.
// When a finished result is not taken, the whole pipeline holds and o_in_ready
// drops in the same cycle.
module skew_lines_closest_midpoint_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  slcm_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output slcm_pkg::t_out_item  o_out_item
);
    import slcm_pkg::*;

    localparam int ST_A   = MUL_LAT + 1;          // n, d x u1, d x u2
    localparam int ST_B   = ST_A + MUL_LAT + 1;   // dot product sums
    localparam int ST_B2  = ST_B + 1;             // parallel check, negation
    localparam int ST_C   = ST_B2 + MUL_LAT + 1;  // partial numerator sums
    localparam int ST_C2  = ST_C + 1;             // numerator, divisor
    localparam int ST_OUT = ST_C2 + Q_BITS + 2;   // output register

    logic en;
    logic [ST_OUT:0] r_vld;

    t_in_item r_in;
    logic signed [W_IN-1:0] p1v [3];
    logic signed [W_IN-1:0] u1v [3];
    logic signed [W_IN-1:0] p2v [3];
    logic signed [W_IN-1:0] u2v [3];
    logic signed [W_D-1:0]  dv  [3];
    logic signed [W_D-1:0]  sv  [3];

    logic signed [W_PA-1:0] ma_na  [3];
    logic signed [W_PA-1:0] ma_nb  [3];
    logic signed [W_PC-1:0] ma_c2a [3];
    logic signed [W_PC-1:0] ma_c2b [3];
    logic signed [W_PC-1:0] ma_c1a [3];
    logic signed [W_PC-1:0] ma_c1b [3];

    logic signed [W_N-1:0]  r_n  [3];
    logic signed [W_C-1:0]  r_c2 [3];
    logic signed [W_C-1:0]  r_c1 [3];

    logic signed [W_PNN-1:0] mb_nn [3];
    logic signed [W_PT-1:0]  mb_t2 [3];
    logic signed [W_PT-1:0]  mb_t1 [3];

    logic signed [W_DS-1:0] r_dsum;
    logic signed [W_T-1:0]  r_t2sum;
    logic signed [W_T-1:0]  r_t1sum;

    logic                   n_par;
    logic signed [W_DS-1:0] n_dp;
    logic signed [W_DS-1:0] r_dp;
    logic signed [W_T-1:0]  r_n1;
    logic signed [W_T-1:0]  r_n2;
    logic signed [W_A-1:0]  r_e;
    logic                   r_par;

    logic signed [W_D-1:0]  r_s_d  [1:ST_B2][3];
    logic signed [W_IN-1:0] r_u1_d [1:ST_B2][3];
    logic signed [W_IN-1:0] r_u2_d [1:ST_B2][3];

    logic signed [W_PS-1:0] mc_sd [3];
    logic signed [W_PU-1:0] mc_a  [3];
    logic signed [W_PU-1:0] mc_b  [3];

    logic signed [W_A-1:0]  r_e_d  [ST_B2+1:ST_C-1];
    logic signed [W_DS-1:0] r_dp_d [ST_B2+1:ST_C];
    logic [ST_OUT-1:ST_B2+1] r_par_d;

    logic signed [W_A-1:0]  r_x [3];
    logic signed [W_A-1:0]  r_y [3];
    logic signed [W_A-1:0]  r_a [3];
    logic [W_B-1:0]         r_b;
    logic signed [W_IN-1:0] dq  [3];

    t_out_item r_out;

    // the whole pipeline advances together; it holds only while a result waits
    assign en          = !r_vld[ST_OUT] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[ST_OUT];
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[ST_OUT-1:0], i_in_valid};
        end
    end

    // input register and point sums/differences
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_in_item;
        end
    end

    always_comb begin
        p1v[0] = r_in.first_point_x;
        p1v[1] = r_in.first_point_y;
        p1v[2] = r_in.first_point_z;
        u1v[0] = r_in.first_dir_x;
        u1v[1] = r_in.first_dir_y;
        u1v[2] = r_in.first_dir_z;
        p2v[0] = r_in.second_point_x;
        p2v[1] = r_in.second_point_y;
        p2v[2] = r_in.second_point_z;
        u2v[0] = r_in.second_dir_x;
        u2v[1] = r_in.second_dir_y;
        u2v[2] = r_in.second_dir_z;
        for (int k = 0; k < 3; k++) begin
            dv[k] = W_D'(p1v[k]) - W_D'(p2v[k]);
            sv[k] = W_D'(p1v[k]) + W_D'(p2v[k]);
        end
    end

    genvar gk;
    for (gk = 0; gk < 3; gk++) begin : g_cross
        localparam int K1 = (gk + 1) % 3;
        localparam int K2 = (gk + 2) % 3;

        slcm_mul #(.WX(W_IN), .WY(W_IN)) u_na (
            .i_clk, .i_en(en), .i_x(u1v[K1]), .i_y(u2v[K2]), .o_p(ma_na[gk])
        );
        slcm_mul #(.WX(W_IN), .WY(W_IN)) u_nb (
            .i_clk, .i_en(en), .i_x(u1v[K2]), .i_y(u2v[K1]), .o_p(ma_nb[gk])
        );
        slcm_mul #(.WX(W_D), .WY(W_IN)) u_c2a (
            .i_clk, .i_en(en), .i_x(dv[K1]), .i_y(u2v[K2]), .o_p(ma_c2a[gk])
        );
        slcm_mul #(.WX(W_D), .WY(W_IN)) u_c2b (
            .i_clk, .i_en(en), .i_x(dv[K2]), .i_y(u2v[K1]), .o_p(ma_c2b[gk])
        );
        slcm_mul #(.WX(W_D), .WY(W_IN)) u_c1a (
            .i_clk, .i_en(en), .i_x(dv[K1]), .i_y(u1v[K2]), .o_p(ma_c1a[gk])
        );
        slcm_mul #(.WX(W_D), .WY(W_IN)) u_c1b (
            .i_clk, .i_en(en), .i_x(dv[K2]), .i_y(u1v[K1]), .o_p(ma_c1b[gk])
        );

        slcm_mul #(.WX(W_N), .WY(W_N)) u_nn (
            .i_clk, .i_en(en), .i_x(r_n[gk]), .i_y(r_n[gk]), .o_p(mb_nn[gk])
        );
        slcm_mul #(.WX(W_C), .WY(W_N)) u_t2 (
            .i_clk, .i_en(en), .i_x(r_c2[gk]), .i_y(r_n[gk]), .o_p(mb_t2[gk])
        );
        slcm_mul #(.WX(W_C), .WY(W_N)) u_t1 (
            .i_clk, .i_en(en), .i_x(r_c1[gk]), .i_y(r_n[gk]), .o_p(mb_t1[gk])
        );

        slcm_mul #(.WX(W_D), .WY(W_DS)) u_sd (
            .i_clk, .i_en(en), .i_x(r_s_d[ST_B2][gk]), .i_y(r_dp), .o_p(mc_sd[gk])
        );
        slcm_mul #(.WX(W_T), .WY(W_IN)) u_ma (
            .i_clk, .i_en(en), .i_x(r_n1), .i_y(r_u1_d[ST_B2][gk]), .o_p(mc_a[gk])
        );
        slcm_mul #(.WX(W_T), .WY(W_IN)) u_mb (
            .i_clk, .i_en(en), .i_x(r_n2), .i_y(r_u2_d[ST_B2][gk]), .o_p(mc_b[gk])
        );

        slcm_div u_div (
            .i_clk, .i_en(en), .i_num(r_a[gk]), .i_den(r_b), .o_quo(dq[gk])
        );
    end

    // cross products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k]  <= W_N'(ma_na[k]) - W_N'(ma_nb[k]);
                r_c2[k] <= W_C'(ma_c2a[k]) - W_C'(ma_c2b[k]);
                r_c1[k] <= W_C'(ma_c1a[k]) - W_C'(ma_c1b[k]);
            end
        end
    end

    // dot products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dsum  <= W_DS'(mb_nn[0]) + W_DS'(mb_nn[1]) + W_DS'(mb_nn[2]);
            r_t2sum <= W_T'(mb_t2[0]) + W_T'(mb_t2[1]) + W_T'(mb_t2[2]);
            r_t1sum <= W_T'(mb_t1[0]) + W_T'(mb_t1[1]) + W_T'(mb_t1[2]);
        end
    end

    // parallel lines: D forced to 1 and both N to 0 gives floor((S + 1) / 2)
    assign n_par = (r_dsum == '0);
    assign n_dp  = n_par ? W_DS'(1) : r_dsum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dp  <= n_dp;
            r_n1  <= n_par ? '0 : -r_t2sum;
            r_n2  <= n_par ? '0 : -r_t1sum;
            r_e   <= W_A'(n_dp) + (W_A'(n_dp) <<< Q_BITS);   // D + 2^32 * D
            r_par <= n_par;
        end
    end

    // point sums and directions ride along to the last multiplier section
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_s_d[1][k]  <= sv[k];
                r_u1_d[1][k] <= u1v[k];
                r_u2_d[1][k] <= u2v[k];
            end
            for (int j = 2; j <= ST_B2; j++) begin
                r_s_d[j]  <= r_s_d[j-1];
                r_u1_d[j] <= r_u1_d[j-1];
                r_u2_d[j] <= r_u2_d[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_d[ST_B2+1]  <= r_e;
            r_dp_d[ST_B2+1] <= r_dp;
            for (int j = ST_B2 + 2; j <= ST_C - 1; j++) begin
                r_e_d[j] <= r_e_d[j-1];
            end
            for (int j = ST_B2 + 2; j <= ST_C; j++) begin
                r_dp_d[j] <= r_dp_d[j-1];
            end
            r_par_d <= {r_par_d[ST_OUT-2:ST_B2+1], r_par};
        end
    end

    // numerator: S*D + N1*u1 + N2*u2 + D + 2^32*D, divisor 2*D
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_x[k] <= W_A'(mc_sd[k]) + W_A'(mc_a[k]);
                r_y[k] <= W_A'(mc_b[k]) + r_e_d[ST_C-1];
                r_a[k] <= r_x[k] + r_y[k];
            end
            r_b <= {r_dp_d[ST_C], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.closest_x      <= dq[0];
            r_out.closest_y      <= dq[1];
            r_out.closest_z      <= dq[2];
            r_out.lines_parallel <= r_par_d[ST_OUT-1];
        end
    end

endmodule

FILE: hdl/slcm_chk.sv
// Port-level checker for the closest-midpoint block, bound to the top level.
`include "skew_lines_closest_midpoint_top_assert.svh"

module slcm_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input slcm_pkg::t_out_item o_out_item
);
    import slcm_pkg::*;

    // an empty output slot never blocks input
    `SLCM_ASSERT_NOW(a_ready_when_free, !o_out_valid, o_in_ready, "input blocked with free output")

    // a held result freezes the pipeline
    `SLCM_ASSERT_NOW(a_stall_blocks_in, o_out_valid && !i_out_ready, !o_in_ready, "item taken during stall")

    `SLCM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result changed while held")

    `SLCM_ASSERT_NOW(a_out_drop, $fell(o_out_valid) && $past(i_rst_n), $past(i_out_ready), "result dropped untaken")

endmodule

bind skew_lines_closest_midpoint_top slcm_chk u_slcm_chk (.*);

FILE: tb/tb_top.sv
// Testbench for the closest-midpoint block: directed table plus random items, checked by predictor.
module tb_top;
    import slcm_pkg::*;

    localparam int LATENCY   = 54;
    localparam int WATCHDOG  = 5000;
    localparam int N_RANDOM  = 600;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        t_in_item  item;
        logic      has_want;
        t_out_item want;
    } t_stim_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    t_out_item pending_points[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        quiet_tail = 0;
    bit        hold_sink = 0;
    t_stim_row dir_rows[$];

    skew_lines_closest_midpoint_top dut (.*);

    always #5 i_clk = ~i_clk;

    // exact floor division, positive divisor
    function automatic t_wide floor_div(t_wide a, t_wide b);
        t_wide q;
        q = a / b;
        if ((a % b != 0) && (a < 0)) q = q - 1;
        return q;
    endfunction

    function automatic logic signed [31:0] clamp32(t_wide v);
        if (v > t_wide'(SAT_MAX)) return SAT_MAX;
        if (v < t_wide'(SAT_MIN)) return SAT_MIN;
        return v[31:0];
    endfunction

    function automatic t_out_item closest_midpoint(t_in_item it);
        t_wide p1[3], u1[3], p2[3], u2[3], dv[3], sv[3], nv[3], c1[3], c2[3];
        t_wide dd, half, num, n1, n2;
        t_out_item r;
        logic signed [31:0] res[3];
        p1[0] = it.first_point_x;  p1[1] = it.first_point_y;  p1[2] = it.first_point_z;
        u1[0] = it.first_dir_x;    u1[1] = it.first_dir_y;    u1[2] = it.first_dir_z;
        p2[0] = it.second_point_x; p2[1] = it.second_point_y; p2[2] = it.second_point_z;
        u2[0] = it.second_dir_x;   u2[1] = it.second_dir_y;   u2[2] = it.second_dir_z;
        for (int k = 0; k < 3; k++) begin
            dv[k] = p1[k] - p2[k];
            sv[k] = p1[k] + p2[k];
        end
        nv[0] = u1[1]*u2[2] - u1[2]*u2[1];
        nv[1] = u1[2]*u2[0] - u1[0]*u2[2];
        nv[2] = u1[0]*u2[1] - u1[1]*u2[0];
        dd = nv[0]*nv[0] + nv[1]*nv[1] + nv[2]*nv[2];
        c2[0] = dv[1]*u2[2] - dv[2]*u2[1];
        c2[1] = dv[2]*u2[0] - dv[0]*u2[2];
        c2[2] = dv[0]*u2[1] - dv[1]*u2[0];
        c1[0] = dv[1]*u1[2] - dv[2]*u1[1];
        c1[1] = dv[2]*u1[0] - dv[0]*u1[2];
        c1[2] = dv[0]*u1[1] - dv[1]*u1[0];
        n1 = -(c2[0]*nv[0] + c2[1]*nv[1] + c2[2]*nv[2]);
        n2 = -(c1[0]*nv[0] + c1[1]*nv[1] + c1[2]*nv[2]);
        half = (dd == 0) ? 1 : dd;
        for (int k = 0; k < 3; k++) begin
            num = (dd == 0) ? sv[k] : sv[k]*dd + n1*u1[k] + n2*u2[k];
            res[k] = clamp32(floor_div(num + half, half + half));
        end
        r.closest_x = res[0];
        r.closest_y = res[1];
        r.closest_z = res[2];
        r.lines_parallel = (dd == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, t_out_item got, t_out_item want);
        mismatches++;
        $display("ERROR %s: got %h %h %h par=%0b, want %h %h %h par=%0b", what,
                 got.closest_x, got.closest_y, got.closest_z, got.lines_parallel,
                 want.closest_x, want.closest_y, want.closest_z, want.lines_parallel);
    endtask

    // mix of extremes, small values and full-range words
    function automatic logic [31:0] pick_word(int mode);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3, 4: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
            5, 6: return (mode == 0) ? $urandom : 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        logic [31:0] w[12];
        int mode;
        mode = $urandom_range(0, 1);
        for (int k = 0; k < 12; k++) w[k] = pick_word(mode);
        it = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8], w[9], w[10], w[11]};
        // sometimes make the directions parallel or zero
        case ($urandom_range(0, 9))
            0: {it.second_dir_x, it.second_dir_y, it.second_dir_z} =
                   {it.first_dir_x, it.first_dir_y, it.first_dir_z};
            1: {it.first_dir_x, it.first_dir_y, it.first_dir_z} = '0;
            2: {it.second_dir_x, it.second_dir_y, it.second_dir_z} =
                   {-it.first_dir_x, -it.first_dir_y, -it.first_dir_z};
            default: ;
        endcase
        return it;
    endfunction

    task automatic add_row(t_in_item it, logic has, t_out_item want);
        t_stim_row r;
        r.item = it;
        r.has_want = has;
        r.want = want;
        dir_rows.push_back(r);
    endtask

    task automatic send_item(t_in_item it);
        i_in_item <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_points.push_back(closest_midpoint(it));
        @(negedge i_clk);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
    endtask

    // sink side
    initial begin
        @(negedge i_clk);
        forever begin
            if (!hold_sink && !quiet_tail && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            i_out_ready <= !hold_sink;
            @(negedge i_clk);
        end
    end

    // checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_points.size() == 0) begin
                    report_mismatch("unexpected item", o_out_item, '0);
                end else begin
                    t_out_item w;
                    w = pending_points.pop_front();
                    if (o_out_item.closest_x !== w.closest_x ||
                        o_out_item.closest_y !== w.closest_y ||
                        o_out_item.closest_z !== w.closest_z ||
                        o_out_item.lines_parallel !== w.lines_parallel)
                        report_mismatch("field mismatch", o_out_item, w);
                end
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        t_in_item it;
        t_out_item w;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all zero: parallel, midpoint zero
        add_row('0, 1'b1, '{0, 0, 0, 1'b1});
        // zero directions, extreme points: midpoint rounds toward +inf
        it = '0;
        {it.first_point_x, it.first_point_y, it.first_point_z} =
            {SAT_MAX, SAT_MIN, SAT_MAX};
        {it.second_point_x, it.second_point_y, it.second_point_z} =
            {SAT_MAX, SAT_MIN, SAT_MIN};
        add_row(it, 1'b1, '{SAT_MAX, SAT_MIN, 0, 1'b1});
        // x axis and y axis offset in z by 2.0: closest-approach midpoint at z = 1.0
        it = '0;
        it.first_dir_x = 32'sh1_0000;
        it.second_dir_y = 32'sh1_0000;
        it.second_point_z = 32'sh2_0000;
        add_row(it, 1'b1, '{0, 0, 32'sh1_0000, 1'b0});
        // opposite directions (parallel), distinct points
        it = '0;
        it.first_dir_x = 32'sh3_0000;
        it.second_dir_x = -32'sh1_0000;
        it.first_point_y = 32'sh5;
        it.second_point_y = 32'sh2;
        add_row(it, 1'b1, '{0, 32'sh4, 0, 1'b1});
        // extreme directions, predictor only
        it = {12{SAT_MIN}};
        it.second_dir_y = SAT_MAX;
        add_row(it, 1'b0, '0);
        it = {12{SAT_MAX}};
        it.first_dir_z = SAT_MIN;
        it.second_point_x = SAT_MIN;
        add_row(it, 1'b0, '0);
        // nearly parallel with far points: saturation
        it = '0;
        it.first_dir_x = 32'sh7FFF_FFFF;
        it.first_dir_y = 32'sh1;
        it.second_dir_x = 32'sh7FFF_FFFF;
        it.second_point_z = SAT_MAX;
        it.second_point_y = SAT_MIN;
        add_row(it, 1'b0, '0);
        for (int k = 0; k < 8; k++) add_row(random_item(), 1'b0, '0);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].has_want) begin
                w = closest_midpoint(dir_rows[k].item);
                if (w !== dir_rows[k].want) report_mismatch("table row", w, dir_rows[k].want);
            end
            send_item(dir_rows[k].item);
        end

        // sender pauses until every result is back
        i_in_valid <= 1'b0;
        wait (pending_points.size() == 0);
        @(negedge i_clk);

        // receiver holds off while the sender keeps offering items
        hold_sink = 1;
        fork
            begin
                repeat (150) @(negedge i_clk);
                hold_sink = 0;
            end
            for (int k = 0; k < 100; k++) send_item(random_item());
        join

        for (int k = 0; k < N_RANDOM - 100; k++) begin
            if (k == N_RANDOM - 180) quiet_tail = 1;
            send_item(random_item());
        end
        i_in_valid <= 1'b0;

        wait (pending_points.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
